[design/tbpq_pkg.sv]
`default_nettype none
package tbpq_pkg;

    localparam int HANDLE_W   = 16;
    localparam int LEN_W      = 16;
    localparam int ETYPE_W    = 16;
    localparam int TRAFFIC_W  = 8;
    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int BAND_W     = 2;
    localparam int PRIO_W     = 4;
    localparam int CNT_W      = 11;
    localparam int BACKLOG_W  = 26;
    localparam int PKTS_W     = 32;
    localparam int BYTES_W    = 64;
    localparam int MAP_W      = 32;
    localparam int WORD_W     = HANDLE_W + LEN_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam int BAND_COUNT        = 3;
    localparam int MAX_VLAN_TAGS     = 2;
    localparam int DEF_QUEUE_DEPTH   = 1024;

    localparam logic [BAND_W-1:0]  BAND_LAST   = 2'd2;
    localparam logic [ETYPE_W-1:0] ETYPE_VLAN  = 16'h8100;
    localparam logic [ETYPE_W-1:0] ETYPE_IPV4  = 16'h0800;
    localparam logic [ETYPE_W-1:0] ETYPE_IPV6  = 16'h86DD;

    localparam logic [CNT_W-1:0] LIMIT_RESET = 11'd1024;
    localparam logic [MAP_W-1:0] MAP_RESET   = 32'h5555_09A9;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MAP    = 8'd1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_RESET   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ENQUEUED   = 3'd0,
        ST_DROPPED    = 3'd1,
        ST_DEQUEUED   = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_PEEKED     = 3'd4,
        ST_RESET_DONE = 3'd5
    } status_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [HANDLE_W-1:0]  packet_handle;
        logic [LEN_W-1:0]     packet_length;
        logic [ETYPE_W-1:0]   outer_ether_type;
        logic [ETYPE_W-1:0]   first_inner_ether_type;
        logic [ETYPE_W-1:0]   second_inner_ether_type;
        logic [TRAFFIC_W-1:0] traffic_byte;
        logic                 header_complete;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [HANDLE_W-1:0]  out_handle;
        logic [LEN_W-1:0]     out_length;
        logic [BAND_W-1:0]    band_used;
        logic [CNT_W-1:0]     total_queued;
        logic [BACKLOG_W-1:0] backlog_total;
        logic [PKTS_W-1:0]    sent_packets;
        logic [BYTES_W-1:0]   sent_bytes;
    } rsp_t;

    // outcome of the queue control stage, finished by the stats stage
    typedef struct packed {
        status_t           status;
        logic [BAND_W-1:0] band;
        logic              use_mem;
        logic              enq;
        logic              deq;
        logic              clr;
        logic [LEN_W-1:0]  length;
        logic [CNT_W-1:0]  total;
    } ctrl_res_t;

endpackage
`default_nettype wire

[design/tbpq_req_if.sv]
`default_nettype none
interface tbpq_req_if;
    logic          valid;
    logic          ready;
    tbpq_pkg::req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/tbpq_rsp_if.sv]
`default_nettype none
interface tbpq_rsp_if;
    logic          valid;
    logic          ready;
    tbpq_pkg::rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[design/tbpq_cfg_if.sv]
`default_nettype none
interface tbpq_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tbpq_pkg::CFG_IDX_W-1:0]  index;
    logic [tbpq_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[design/tbpq_classify.sv]
`default_nettype none
module tbpq_classify (
    input  wire tbpq_pkg::req_t                  item,
    input  wire logic [tbpq_pkg::MAP_W-1:0]      band_map,
    output logic [tbpq_pkg::BAND_W-1:0]          band
);

    logic [tbpq_pkg::ETYPE_W-1:0] etype;
    logic [tbpq_pkg::PRIO_W-1:0]  prio;
    logic [tbpq_pkg::BAND_W-1:0]  entry;

    always_comb
    begin
        etype = item.outer_ether_type;
        // peel vlan tags, at most the configured number
        if (tbpq_pkg::MAX_VLAN_TAGS >= 1 && etype == tbpq_pkg::ETYPE_VLAN)
        begin
            etype = item.first_inner_ether_type;
        end
        if (tbpq_pkg::MAX_VLAN_TAGS >= 2 && etype == tbpq_pkg::ETYPE_VLAN)
        begin
            etype = item.second_inner_ether_type;
        end

        if ((etype == tbpq_pkg::ETYPE_IPV4 || etype == tbpq_pkg::ETYPE_IPV6)
            && item.header_complete)
        begin
            prio = item.traffic_byte[4:1];
        end
        else
        begin
            prio = '0;
        end

        entry = band_map[{prio, 1'b0} +: tbpq_pkg::BAND_W];
        // map code 3 folds into the last band
        band  = (entry > tbpq_pkg::BAND_LAST) ? tbpq_pkg::BAND_LAST : entry;
    end

endmodule
`default_nettype wire

[design/tbpq_band_ram.sv]
`default_nettype none
module tbpq_band_ram #(
    parameter int DEPTH  = tbpq_pkg::DEF_QUEUE_DEPTH,
    parameter int ADDR_W = $clog2(tbpq_pkg::DEF_QUEUE_DEPTH)
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [tbpq_pkg::WORD_W-1:0] wr_data,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic [tbpq_pkg::WORD_W-1:0]      rd_data
);

    logic [tbpq_pkg::WORD_W-1:0] mem [DEPTH];
    logic [tbpq_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[design/tbpq_queue_ctrl.sv]
`default_nettype none
module tbpq_queue_ctrl #(
    parameter int QUEUE_DEPTH = tbpq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            go,
    input  wire tbpq_pkg::req_t                  item,
    input  wire logic [tbpq_pkg::CNT_W-1:0]      queue_limit,
    input  wire logic [tbpq_pkg::MAP_W-1:0]      band_map,
    output tbpq_pkg::ctrl_res_t                  res,
    output logic [tbpq_pkg::WORD_W-1:0]          rd_word
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int NB    = tbpq_pkg::BAND_COUNT;

    logic [PTR_W-1:0]           head_reg  [NB];
    logic [PTR_W-1:0]           head_next [NB];
    logic [PTR_W-1:0]           tail_reg  [NB];
    logic [PTR_W-1:0]           tail_next [NB];
    logic [tbpq_pkg::CNT_W-1:0] count_reg  [NB];
    logic [tbpq_pkg::CNT_W-1:0] count_next [NB];
    logic [tbpq_pkg::CNT_W-1:0] total_reg;
    logic [tbpq_pkg::CNT_W-1:0] total_next;
    logic [tbpq_pkg::BAND_W-1:0] sel_reg;
    logic [tbpq_pkg::BAND_W-1:0] sel_next;

    logic [NB-1:0]               wr_en;
    logic [NB-1:0]               rd_en;
    logic [NB-1:0]               nonempty;
    logic                        any_queued;
    logic [tbpq_pkg::BAND_W-1:0] low_band;
    logic [tbpq_pkg::BAND_W-1:0] cls_band;
    logic                        full;
    logic [tbpq_pkg::WORD_W-1:0] rd_data [NB];

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        next_slot = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    tbpq_classify u_classify (
        .item     (item),
        .band_map (band_map),
        .band     (cls_band)
    );

    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            nonempty[b] = (count_reg[b] != '0);
        end
        any_queued = |nonempty;
        if (nonempty[0])
        begin
            low_band = 2'd0;
        end
        else if (nonempty[1])
        begin
            low_band = 2'd1;
        end
        else
        begin
            low_band = 2'd2;
        end
        full = (total_reg >= queue_limit) || (32'(total_reg) >= 32'(QUEUE_DEPTH));
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        total_next = total_reg;
        sel_next   = sel_reg;
        wr_en      = '0;
        rd_en      = '0;

        res.status  = tbpq_pkg::ST_ENQUEUED;
        res.band    = '0;
        res.use_mem = 1'b0;
        res.enq     = 1'b0;
        res.deq     = 1'b0;
        res.clr     = 1'b0;
        res.length  = item.packet_length;

        case (tbpq_pkg::action_t'(item.action))
            tbpq_pkg::ACT_ENQUEUE:
            begin
                if (full)
                begin
                    res.status = tbpq_pkg::ST_DROPPED;
                end
                else
                begin
                    res.status           = tbpq_pkg::ST_ENQUEUED;
                    res.band             = cls_band;
                    res.enq              = 1'b1;
                    wr_en[cls_band]      = 1'b1;
                    tail_next[cls_band]  = next_slot(tail_reg[cls_band]);
                    count_next[cls_band] = count_reg[cls_band] + 1'b1;
                    total_next           = total_reg + 1'b1;
                end
            end
            tbpq_pkg::ACT_DEQUEUE, tbpq_pkg::ACT_PEEK:
            begin
                if (!any_queued)
                begin
                    res.status = tbpq_pkg::ST_EMPTY;
                end
                else
                begin
                    res.band        = low_band;
                    res.use_mem     = 1'b1;
                    rd_en[low_band] = 1'b1;
                    sel_next        = low_band;
                    if (tbpq_pkg::action_t'(item.action) == tbpq_pkg::ACT_DEQUEUE)
                    begin
                        res.status           = tbpq_pkg::ST_DEQUEUED;
                        res.deq              = 1'b1;
                        head_next[low_band]  = next_slot(head_reg[low_band]);
                        count_next[low_band] = count_reg[low_band] - 1'b1;
                        total_next           = total_reg - 1'b1;
                    end
                    else
                    begin
                        res.status = tbpq_pkg::ST_PEEKED;
                    end
                end
            end
            tbpq_pkg::ACT_RESET:
            begin
                res.status = tbpq_pkg::ST_RESET_DONE;
                res.clr    = 1'b1;
                for (int b = 0; b < NB; b++)
                begin
                    head_next[b]  = '0;
                    tail_next[b]  = '0;
                    count_next[b] = '0;
                end
                total_next = '0;
            end
            default:
            begin
            end
        endcase

        res.total = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NB; b++)
            begin
                head_reg[b]  <= '0;
                tail_reg[b]  <= '0;
                count_reg[b] <= '0;
            end
            total_reg <= '0;
            sel_reg   <= '0;
        end
        else if (go)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            total_reg <= total_next;
            sel_reg   <= sel_next;
        end
    end

    for (genvar b = 0; b < NB; b++)
    begin : g_band
        tbpq_band_ram #(
            .DEPTH  (QUEUE_DEPTH),
            .ADDR_W (PTR_W)
        ) u_ram (
            .clk     (clk),
            .wr_en   (go && wr_en[b]),
            .wr_addr (tail_reg[b]),
            .wr_data ({item.packet_handle, item.packet_length}),
            .rd_en   (go && rd_en[b]),
            .rd_addr (head_reg[b]),
            .rd_data (rd_data[b])
        );
    end

    // read data stays put until the next read, so a stalled result keeps it
    assign rd_word = rd_data[sel_reg];

endmodule
`default_nettype wire

[design/tbpq_stats.sv]
`default_nettype none
module tbpq_stats (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        go,
    input  wire tbpq_pkg::ctrl_res_t         res,
    input  wire logic [tbpq_pkg::WORD_W-1:0] rd_word,
    output tbpq_pkg::rsp_t                   rsp_next
);

    logic [tbpq_pkg::BACKLOG_W-1:0] backlog_reg;
    logic [tbpq_pkg::BACKLOG_W-1:0] backlog_next;
    logic [tbpq_pkg::PKTS_W-1:0]    pkts_reg;
    logic [tbpq_pkg::PKTS_W-1:0]    pkts_next;
    logic [tbpq_pkg::BYTES_W-1:0]   bytes_reg;
    logic [tbpq_pkg::BYTES_W-1:0]   bytes_next;
    logic [tbpq_pkg::HANDLE_W-1:0]  ohandle;
    logic [tbpq_pkg::LEN_W-1:0]     olength;

    always_comb
    begin
        ohandle = res.use_mem ? rd_word[tbpq_pkg::WORD_W-1:tbpq_pkg::LEN_W] : '0;
        olength = res.use_mem ? rd_word[tbpq_pkg::LEN_W-1:0] : '0;

        backlog_next = backlog_reg;
        pkts_next    = pkts_reg;
        bytes_next   = bytes_reg;
        if (res.clr)
        begin
            backlog_next = '0;
        end
        else if (res.enq)
        begin
            backlog_next = backlog_reg + tbpq_pkg::BACKLOG_W'(res.length);
        end
        else if (res.deq)
        begin
            backlog_next = backlog_reg - tbpq_pkg::BACKLOG_W'(olength);
            pkts_next    = pkts_reg + 1'b1;
            bytes_next   = bytes_reg + tbpq_pkg::BYTES_W'(olength);
        end

        rsp_next.status        = res.status;
        rsp_next.out_handle    = ohandle;
        rsp_next.out_length    = olength;
        rsp_next.band_used     = res.band;
        rsp_next.total_queued  = res.total;
        rsp_next.backlog_total = backlog_next;
        rsp_next.sent_packets  = pkts_next;
        rsp_next.sent_bytes    = bytes_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            backlog_reg <= '0;
            pkts_reg    <= '0;
            bytes_reg   <= '0;
        end
        else if (go)
        begin
            backlog_reg <= backlog_next;
            pkts_reg    <= pkts_next;
            bytes_reg   <= bytes_next;
        end
    end

endmodule
`default_nettype wire

[design/three_band_priority_packet_queue_top.sv]
`default_nettype none
// Three-band priority packet queue. Each beat on req is one action (enqueue, dequeue, peek
// or reset) and gives exactly one beat on rsp, in order. One action is accepted every clock
// cycle while rsp is not back-pressured; the request lands in the input register, then queue
// control with the band memory read, then the statistics update into the result register.
// The bands are three memories of QUEUE_DEPTH descriptors each with a registered read port;
// pointers and counts live in flip-flops, so no clearing pass is needed after reset.
// Configuration writes on cfg are always taken and belong to idle periods.
module three_band_priority_packet_queue_top #(
    parameter int QUEUE_DEPTH = tbpq_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tbpq_req_if.sink   req,
    tbpq_rsp_if.source rsp,
    tbpq_cfg_if.sink   cfg
);

    logic                          v1_reg;
    logic                          v2_reg;
    logic                          v3_reg;
    tbpq_pkg::req_t                item_reg;
    tbpq_pkg::ctrl_res_t           ctrl_res_reg;
    tbpq_pkg::ctrl_res_t           ctrl_res;
    tbpq_pkg::rsp_t                rsp_reg;
    tbpq_pkg::rsp_t                rsp_next;
    logic [tbpq_pkg::WORD_W-1:0]   rd_word;
    logic [tbpq_pkg::CNT_W-1:0]    queue_limit_reg;
    logic [tbpq_pkg::MAP_W-1:0]    band_map_reg;
    logic                          adv2;
    logic                          adv3;

    assign adv3      = v2_reg && (!v3_reg || rsp.ready);
    assign adv2      = v1_reg && (!v2_reg || adv3);
    assign req.ready = !v1_reg || adv2;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg <= tbpq_pkg::LIMIT_RESET;
            band_map_reg    <= tbpq_pkg::MAP_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == tbpq_pkg::REG_QUEUE_LIMIT)
            begin
                queue_limit_reg <= cfg.data[tbpq_pkg::CNT_W-1:0];
            end
            else if (cfg.index == tbpq_pkg::REG_BAND_MAP)
            begin
                band_map_reg <= cfg.data[tbpq_pkg::MAP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                v1_reg <= req.valid;
            end
            if (!v2_reg || adv3)
            begin
                v2_reg <= v1_reg;
            end
            if (!v3_reg || rsp.ready)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= req.payload;
        end
        if (adv2)
        begin
            ctrl_res_reg <= ctrl_res;
        end
        if (adv3)
        begin
            rsp_reg <= rsp_next;
        end
    end

    tbpq_queue_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (adv2),
        .item        (item_reg),
        .queue_limit (queue_limit_reg),
        .band_map    (band_map_reg),
        .res         (ctrl_res),
        .rd_word     (rd_word)
    );

    tbpq_stats u_stats (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (adv3),
        .res      (ctrl_res_reg),
        .rd_word  (rd_word),
        .rsp_next (rsp_next)
    );

    assign rsp.valid   = v3_reg;
    assign rsp.payload = rsp_reg;

    // a stalled middle stage is never overwritten or dropped
    a_mid_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && v3_reg && !rsp.ready) |=> v2_reg)
        else $error("middle stage lost while output stalled");

    a_reset_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && rsp_reg.status == tbpq_pkg::ST_RESET_DONE)
        |-> (rsp_reg.total_queued == '0 && rsp_reg.backlog_total == '0))
        else $error("reset action left occupancy behind");

    a_empty_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (rsp_reg.status == tbpq_pkg::ST_EMPTY
                    || rsp_reg.status == tbpq_pkg::ST_DROPPED))
        |-> (rsp_reg.out_handle == '0 && rsp_reg.out_length == '0
             && rsp_reg.band_used == '0))
        else $error("empty or drop result carries descriptor data");

    a_dequeue_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (adv2 && ctrl_res.deq) |-> (ctrl_res.total != '1))
        else $error("dequeue underflowed the total count");

endmodule
`default_nettype wire

[dv/tb.sv]
`default_nettype none
module tb;
    import tbpq_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        req_t op;
        bit   typed;
        rsp_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    tbpq_req_if req_ch ();
    tbpq_rsp_if rsp_ch ();
    tbpq_cfg_if cfg_ch ();

    three_band_priority_packet_queue_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always #4 clk = ~clk;

    // queue state as the block should hold it
    logic [WORD_W-1:0]    band_mem [BAND_COUNT][DEPTH];
    int                   head_ptr [BAND_COUNT] = '{0, 0, 0};
    int                   tail_ptr [BAND_COUNT] = '{0, 0, 0};
    int                   fill_cnt [BAND_COUNT] = '{0, 0, 0};
    int                   held_total = 0;
    logic [BACKLOG_W-1:0] backlog_sum = '0;
    logic [PKTS_W-1:0]    pkts_out = '0;
    logic [BYTES_W-1:0]   bytes_out = '0;
    logic [CNT_W-1:0]     limit_reg = LIMIT_RESET;
    logic [MAP_W-1:0]     map_reg = MAP_RESET;

    rsp_t      pending_results [$];
    stim_row_t dir_rows [$];
    int        fail_count = 0;
    int        cycle_count = 0;
    int        src_idle_pct = 0;
    int        snk_idle_pct = 0;
    rsp_t      got_rsp;
    rsp_t      want_rsp;

    function automatic logic [BAND_W-1:0] pick_band(input req_t r);
        logic [ETYPE_W-1:0] etype;
        logic [PRIO_W-1:0]  prio;
        logic [BAND_W-1:0]  band;
        etype = r.outer_ether_type;
        prio = '0;
        // skip at most two vlan tags
        if (etype == ETYPE_VLAN)
        begin
            etype = r.first_inner_ether_type;
            if (etype == ETYPE_VLAN)
                etype = r.second_inner_ether_type;
        end
        if ((etype == ETYPE_IPV4 || etype == ETYPE_IPV6) && r.header_complete)
            prio = r.traffic_byte[4:1];
        band = map_reg[2*prio +: 2];
        if (band > BAND_LAST)
            band = BAND_LAST;
        return band;
    endfunction

    function automatic rsp_t apply_action(input req_t r);
        rsp_t              res;
        logic [BAND_W-1:0] b;
        int                cap;
        int                lb;
        logic [WORD_W-1:0] word;
        res = '0;
        case (action_t'(r.action))
            ACT_ENQUEUE:
            begin
                cap = (limit_reg > DEPTH) ? DEPTH : int'(limit_reg);
                if (held_total >= cap)
                    res.status = ST_DROPPED;
                else
                begin
                    b = pick_band(r);
                    band_mem[b][tail_ptr[b]] = {r.packet_handle, r.packet_length};
                    tail_ptr[b] = (tail_ptr[b] + 1) % DEPTH;
                    fill_cnt[b]++;
                    held_total++;
                    backlog_sum = backlog_sum + r.packet_length;
                    res.status = ST_ENQUEUED;
                    res.band_used = b;
                end
            end
            ACT_DEQUEUE, ACT_PEEK:
            begin
                lb = -1;
                for (int i = BAND_COUNT - 1; i >= 0; i--)
                    if (fill_cnt[i] != 0)
                        lb = i;
                if (lb < 0)
                    res.status = ST_EMPTY;
                else
                begin
                    word = band_mem[lb][head_ptr[lb]];
                    res.out_handle = word[WORD_W-1:LEN_W];
                    res.out_length = word[LEN_W-1:0];
                    res.band_used = BAND_W'(lb);
                    if (action_t'(r.action) == ACT_DEQUEUE)
                    begin
                        head_ptr[lb] = (head_ptr[lb] + 1) % DEPTH;
                        fill_cnt[lb]--;
                        held_total--;
                        backlog_sum = backlog_sum - word[LEN_W-1:0];
                        pkts_out = pkts_out + 1'b1;
                        bytes_out = bytes_out + word[LEN_W-1:0];
                        res.status = ST_DEQUEUED;
                    end
                    else
                        res.status = ST_PEEKED;
                end
            end
            ACT_RESET:
            begin
                for (int i = 0; i < BAND_COUNT; i++)
                begin
                    head_ptr[i] = 0;
                    tail_ptr[i] = 0;
                    fill_cnt[i] = 0;
                end
                held_total = 0;
                backlog_sum = '0;
                res.status = ST_RESET_DONE;
            end
        endcase
        res.total_queued = CNT_W'(held_total);
        res.backlog_total = backlog_sum;
        res.sent_packets = pkts_out;
        res.sent_bytes = bytes_out;
        return res;
    endfunction

    function automatic req_t make_op(input action_t a, input logic [15:0] h, l, e0, e1, e2,
                                     input logic [7:0] tc, input logic hc);
        req_t r;
        r.action = a;
        r.packet_handle = h;
        r.packet_length = l;
        r.outer_ether_type = e0;
        r.first_inner_ether_type = e1;
        r.second_inner_ether_type = e2;
        r.traffic_byte = tc;
        r.header_complete = hc;
        return r;
    endfunction

    function automatic stim_row_t plain_row(input req_t op);
        stim_row_t row;
        row.op = op;
        row.typed = 1'b0;
        row.want = '0;
        return row;
    endfunction

    // rows known by hand: nothing dequeued yet, so no descriptor out and no send counts
    function automatic stim_row_t typed_row(input req_t op, input status_t st,
                                            input logic [BAND_W-1:0] band, input int total,
                                            input logic [BACKLOG_W-1:0] backlog);
        stim_row_t row;
        row.op = op;
        row.typed = 1'b1;
        row.want = '0;
        row.want.status = st;
        row.want.band_used = band;
        row.want.total_queued = CNT_W'(total);
        row.want.backlog_total = backlog;
        return row;
    endfunction

    function automatic logic [ETYPE_W-1:0] pick_etype();
        int pick;
        pick = $urandom_range(9);
        if (pick < 3)
            return ETYPE_VLAN;
        else if (pick < 6)
            return ETYPE_IPV4;
        else if (pick < 8)
            return ETYPE_IPV6;
        return ETYPE_W'($urandom);
    endfunction

    function automatic req_t random_op(input int enq_w, deq_w, peek_w);
        req_t r;
        int   pick;
        int   len_pick;
        r = req_t'({$urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < enq_w)
        begin
            r.action = ACT_ENQUEUE;
            r.outer_ether_type = pick_etype();
            r.first_inner_ether_type = pick_etype();
            r.second_inner_ether_type = pick_etype();
            r.header_complete = ($urandom_range(9) != 0);
            len_pick = $urandom_range(9);
            if (len_pick == 0)
                r.packet_length = '1;
            else if (len_pick == 1)
                r.packet_length = '0;
        end
        else if (pick < enq_w + deq_w)
            r.action = ACT_DEQUEUE;
        else if (pick < enq_w + deq_w + peek_w)
            r.action = ACT_PEEK;
        else
            r.action = ACT_RESET;
        return r;
    endfunction

    task automatic send_op(input req_t r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic issue(input req_t op, input bit typed, input rsp_t want);
        rsp_t predicted;
        predicted = apply_action(op);
        pending_results.push_back(typed ? want : predicted);
        send_op(op);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_QUEUE_LIMIT)
            limit_reg = val[CNT_W-1:0];
        else if (idx == REG_BAND_MAP)
            map_reg = val;
    endtask

    task automatic run_phase(input int lim, input logic [MAP_W-1:0] map, input int n,
                             input int enq_w, deq_w, peek_w, src_pct, snk_pct);
        drain();
        write_reg(REG_QUEUE_LIMIT, CFG_DATA_W'(lim));
        write_reg(REG_BAND_MAP, map);
        cfg_ch.valid <= 1'b0;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int i = 0; i < n; i++)
            issue(random_op(enq_w, deq_w, peek_w), 1'b0, '0);
    endtask

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_rsp = rsp_ch.payload;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no request outstanding");
                fail_count++;
            end
            else
            begin
                want_rsp = pending_results.pop_front();
                check_field("status", want_rsp.status, got_rsp.status);
                check_field("out_handle", want_rsp.out_handle, got_rsp.out_handle);
                check_field("out_length", want_rsp.out_length, got_rsp.out_length);
                check_field("band_used", want_rsp.band_used, got_rsp.band_used);
                check_field("total_queued", want_rsp.total_queued, got_rsp.total_queued);
                check_field("backlog_total", want_rsp.backlog_total, got_rsp.backlog_total);
                check_field("sent_packets", want_rsp.sent_packets, got_rsp.sent_packets);
                check_field("sent_bytes", want_rsp.sent_bytes, got_rsp.sent_bytes);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rsp_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;

        // default limit and map; empty queue first
        dir_rows.push_back(typed_row(make_op(ACT_DEQUEUE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                                             8'h0, 1'b0), ST_EMPTY, 2'd0, 0, 26'd0));
        dir_rows.push_back(typed_row(make_op(ACT_PEEK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                             16'hFFFF, 8'hFF, 1'b1), ST_EMPTY, 2'd0, 0, 26'd0));
        // not ip: priority 0 lands in band 1 under the default map
        dir_rows.push_back(typed_row(make_op(ACT_ENQUEUE, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0,
                                             16'h0, 8'h0, 1'b0), ST_ENQUEUED, 2'd1, 1,
                                     26'hFFFF));
        dir_rows.push_back(typed_row(make_op(ACT_ENQUEUE, 16'h0, 16'h0, 16'hFFFF, 16'hFFFF,
                                             16'hFFFF, 8'hFF, 1'b1), ST_ENQUEUED, 2'd1, 2,
                                     26'hFFFF));
        dir_rows.push_back(typed_row(make_op(ACT_RESET, 16'h1234, 16'h5678, ETYPE_IPV4,
                                             16'h0, 16'h0, 8'h0C, 1'b1), ST_RESET_DONE, 2'd0,
                                     0, 26'd0));
        dir_rows.push_back(typed_row(make_op(ACT_DEQUEUE, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                                             8'h0, 1'b0), ST_EMPTY, 2'd0, 0, 26'd0));
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0101, 16'd64, ETYPE_IPV4,
                                             16'h0, 16'h0, 8'h0C, 1'b1)));
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0202, 16'd1500, ETYPE_IPV6,
                                             16'h0, 16'h0, 8'hFF, 1'b1)));
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0303, 16'd128, ETYPE_VLAN,
                                             ETYPE_IPV4, 16'h0, 8'h0A, 1'b1)));
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0404, 16'd256, ETYPE_VLAN,
                                             ETYPE_VLAN, ETYPE_IPV6, 8'h0E, 1'b1)));
        // a third tag is not skipped
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0505, 16'd9000, ETYPE_VLAN,
                                             ETYPE_VLAN, ETYPE_VLAN, 8'h0C, 1'b1)));
        // truncated ip header
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0606, 16'd40, ETYPE_IPV4,
                                             16'h0, 16'h0, 8'h0C, 1'b0)));
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0707, 16'd60, ETYPE_VLAN,
                                             ETYPE_IPV6, 16'h0, 8'h02, 1'b1)));
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0808, 16'd70, ETYPE_IPV6,
                                             16'h0, 16'h0, 8'hE1, 1'b1)));
        dir_rows.push_back(plain_row(make_op(ACT_ENQUEUE, 16'h0909, 16'd80, ETYPE_IPV4,
                                             16'h0, 16'h0, 8'h0D, 1'b1)));
        dir_rows.push_back(plain_row(make_op(ACT_PEEK, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0,
                                             8'h0, 1'b0)));
        for (int i = 0; i < 10; i++)
            dir_rows.push_back(plain_row(make_op(ACT_DEQUEUE, 16'h0, 16'h0, 16'h0, 16'h0,
                                                 16'h0, 8'h0, 1'b0)));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 23;
        snk_idle_pct = 75;
        foreach (dir_rows[i])
            issue(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].want);

        run_phase(4, $urandom, 120, 50, 30, 15, 23, 75);
        // limit of zero drops every enqueue
        run_phase(0, 32'h0000_0000, 40, 60, 25, 10, 23, 75);
        // every map entry is 3, taken as the last band
        run_phase(1, 32'hFFFF_FFFF, 80, 50, 30, 15, 75, 23);
        // limit above depth: fill to depth and wrap the band 0 tail
        run_phase(2047, 32'h0000_0000, 1250, 96, 3, 1, 75, 23);
        run_phase(1024, $urandom, 80, 45, 35, 15, 0, 0);
        run_phase(9, $urandom, 80, 50, 30, 15, 0, 0);

        drain();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire

[sim.f]
design/tbpq_pkg.sv
design/tbpq_req_if.sv
design/tbpq_rsp_if.sv
design/tbpq_cfg_if.sv
design/tbpq_classify.sv
design/tbpq_band_ram.sv
design/tbpq_queue_ctrl.sv
design/tbpq_stats.sv
design/three_band_priority_packet_queue_top.sv
dv/tb.sv
